FILE: rtl/ihs_pkg.sv
// ----------------------------------------------------------------------------
// ihs_pkg
// Shared types and constants for the image header size sniffer.
// ----------------------------------------------------------------------------
`default_nettype none

package ihs_pkg;

  localparam int unsigned PositionBitsDef = 32;
  localparam int unsigned HdrLen          = 30;
  localparam int unsigned HdrIdxBits      = 5;

  typedef enum logic [2:0] {
    FMT_NONE = 3'd0,
    FMT_PNG  = 3'd1,
    FMT_GIF  = 3'd2,
    FMT_VP8  = 3'd3,
    FMT_VP8L = 3'd4,
    FMT_VP8X = 3'd5,
    FMT_JPEG = 3'd6
  } fmt_e;

  typedef enum logic [5:0] {
    PH_SEEK  = 6'b000001,
    PH_MARK  = 6'b000010,
    PH_LENHI = 6'b000100,
    PH_LENLO = 6'b001000,
    PH_SOF   = 6'b010000,
    PH_DONE  = 6'b100000
  } walk_phase_e;

  localparam logic [7:0] ByteMarker  = 8'hff;
  localparam logic [7:0] ByteSoi     = 8'hd8;
  localparam logic [7:0] BytePngSig  = 8'h89;
  localparam logic [7:0] SofLo       = 8'hc0;
  localparam logic [7:0] SofHi       = 8'hcf;
  localparam logic [7:0] Dht         = 8'hc4;
  localparam logic [7:0] Jpg         = 8'hc8;
  localparam logic [7:0] Dac         = 8'hcc;
  localparam logic [15:0] Vp8Mask    = 16'h3fff;

  typedef logic [HdrLen-1:0][7:0] hdr_arr_t;

  typedef struct packed {
    logic ge4;
    logic ge10;
    logic ge24;
    logic ge30;
  } len_flags_t;

  typedef struct packed {
    logic        ok;
    logic [15:0] width;
    logic [15:0] height;
  } jpeg_res_t;

  typedef struct packed {
    logic        found;
    logic [2:0]  format_code;
    logic [31:0] width;
    logic [31:0] height;
  } result_t;

endpackage

`default_nettype wire

FILE: rtl/ihs_if.sv
// ----------------------------------------------------------------------------
// ihs_if
// Valid/ready stream interfaces for the byte input and the result output.
// ----------------------------------------------------------------------------
`default_nettype none

interface ihs_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       last_byte;

  modport source (output valid, output data_byte, output last_byte, input ready);
  modport sink   (input valid, input data_byte, input last_byte, output ready);
endinterface

interface ihs_out_if;
  logic        valid;
  logic        ready;
  logic        found;
  logic [2:0]  format_code;
  logic [31:0] width;
  logic [31:0] height;

  modport source (output valid, output found, output format_code, output width,
                  output height, input ready);
  modport sink   (input valid, input found, input format_code, input width,
                  input height, output ready);
endinterface

`default_nettype wire

FILE: rtl/ihs_jpeg_walk.sv
// ----------------------------------------------------------------------------
// ihs_jpeg_walk
// JPEG marker walker: skips to the first SOF marker and captures its size.
// ----------------------------------------------------------------------------
`default_nettype none

module ihs_jpeg_walk
  import ihs_pkg::*;
#(
  parameter int unsigned POSITION_BITS = PositionBitsDef
) (
  input  wire logic                     clk_i,
  input  wire logic                     rst_ni,
  input  wire logic                     step_i,
  input  wire logic                     clear_i,
  input  wire logic [POSITION_BITS-1:0] pos_i,
  input  wire logic [7:0]               byte_i,
  output jpeg_res_t                     res_o
);

  localparam int unsigned P = POSITION_BITS;
  localparam logic [P-1:0] PosMax = {P{1'b1}};

  walk_phase_e phase_q, phase_d;
  logic [P-1:0]  next_q, next_d;
  logic [15:0]   seglen_q, seglen_d;
  logic [P-1:0]  sof_pos_q, sof_pos_d;
  logic [31:0]   wh_q, wh_d;
  logic          seen_q, seen_d;

  logic          is_sof;
  logic [P-1:0]  pos_inc;
  logic [15:0]   seg_full;
  logic [P+1:0]  jump;
  logic [P+1:0]  jump_fix;
  logic [P-1:0]  off;
  logic [P:0]    sof_lim;

  assign is_sof = (byte_i >= SofLo) && (byte_i <= SofHi) && (byte_i != Dht) &&
                  (byte_i != Jpg) && (byte_i != Dac);
  assign pos_inc  = (pos_i == PosMax) ? PosMax : pos_i + {{(P-1){1'b0}}, 1'b1};
  assign seg_full = {seglen_q[15:8], byte_i};
  assign jump     = {2'b00, next_q} + (P+2)'(2) + {{(P-14){1'b0}}, seg_full};
  assign jump_fix = (jump <= {2'b00, pos_i}) ? ({2'b00, pos_i} + (P+2)'(1)) : jump;
  assign off      = pos_i - sof_pos_q;

  always_comb begin
    phase_d   = phase_q;
    next_d    = next_q;
    seglen_d  = seglen_q;
    sof_pos_d = sof_pos_q;
    wh_d      = wh_q;
    seen_d    = seen_q;
    if (step_i) begin
      case (phase_q)
        PH_SEEK: begin
          if (pos_i >= next_q) begin
            if (byte_i == ByteMarker) begin
              next_d  = pos_i;
              phase_d = PH_MARK;
            end else begin
              next_d = pos_inc;
            end
          end
        end
        PH_MARK: begin
          if (is_sof) begin
            sof_pos_d = next_q;
            wh_d      = '0;
            phase_d   = PH_SOF;
          end else begin
            phase_d = PH_LENHI;
          end
        end
        PH_LENHI: begin
          seglen_d = {byte_i, 8'h00};
          phase_d  = PH_LENLO;
        end
        PH_LENLO: begin
          seglen_d = seg_full;
          next_d   = (jump_fix[P+1:P] != 2'b00) ? PosMax : jump_fix[P-1:0];
          phase_d  = PH_SEEK;
        end
        PH_SOF: begin
          // bytes merge in, so a saturated position keeps accumulating
          if (off == P'(5)) wh_d[31:24] = wh_q[31:24] | byte_i;
          if (off == P'(6)) wh_d[23:16] = wh_q[23:16] | byte_i;
          if (off == P'(7)) wh_d[15:8]  = wh_q[15:8] | byte_i;
          if (off == P'(8)) begin
            wh_d[7:0] = wh_q[7:0] | byte_i;
            seen_d    = 1'b1;
            phase_d   = PH_DONE;
          end
        end
        PH_DONE: begin
        end
        default: begin
          phase_d = PH_SEEK;
        end
      endcase
    end
  end

  // n >= sof position + 10, with n the byte count after this byte
  assign sof_lim      = {1'b0, sof_pos_d} + (P+1)'(10);
  assign res_o.ok     = seen_d && ({1'b0, pos_inc} >= sof_lim);
  assign res_o.width  = wh_d[15:0];
  assign res_o.height = wh_d[31:16];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q   <= PH_SEEK;
      next_q    <= P'(2);
      seglen_q  <= '0;
      sof_pos_q <= '0;
      wh_q      <= '0;
      seen_q    <= 1'b0;
    end else if (clear_i) begin
      phase_q   <= PH_SEEK;
      next_q    <= P'(2);
      seglen_q  <= '0;
      sof_pos_q <= '0;
      wh_q      <= '0;
      seen_q    <= 1'b0;
    end else begin
      phase_q   <= phase_d;
      next_q    <= next_d;
      seglen_q  <= seglen_d;
      sof_pos_q <= sof_pos_d;
      wh_q      <= wh_d;
      seen_q    <= seen_d;
    end
  end

endmodule

`default_nettype wire

FILE: rtl/ihs_decode.sv
// ----------------------------------------------------------------------------
// ihs_decode
// Format recognition and size extraction from the header bytes.
// ----------------------------------------------------------------------------
`default_nettype none

module ihs_decode
  import ihs_pkg::*;
(
  input  wire hdr_arr_t   hdr_i,
  input  wire len_flags_t len_i,
  input  wire jpeg_res_t  jpeg_i,
  output result_t         res_o
);

  logic        is_png;
  logic        is_gif;
  logic        is_webp;
  logic [31:0] vp8l_bits;

  assign is_png = len_i.ge24 && hdr_i[0] == BytePngSig && hdr_i[1] == 8'h50 &&
                  hdr_i[2] == 8'h4e && hdr_i[3] == 8'h47;
  assign is_gif = len_i.ge10 && hdr_i[0] == 8'h47 && hdr_i[1] == 8'h49 &&
                  hdr_i[2] == 8'h46;
  assign is_webp = len_i.ge30 && hdr_i[0] == 8'h52 && hdr_i[1] == 8'h49 &&
                   hdr_i[2] == 8'h46 && hdr_i[3] == 8'h46 &&
                   hdr_i[8] == 8'h57 && hdr_i[9] == 8'h45 &&
                   hdr_i[10] == 8'h42 && hdr_i[11] == 8'h50 &&
                   hdr_i[12] == 8'h56 && hdr_i[13] == 8'h50 && hdr_i[14] == 8'h38 &&
                   (hdr_i[15] == 8'h20 || hdr_i[15] == 8'h4c || hdr_i[15] == 8'h58);
  assign vp8l_bits = {hdr_i[24], hdr_i[23], hdr_i[22], hdr_i[21]};

  always_comb begin
    res_o = '0;
    if (is_png) begin
      res_o.format_code = FMT_PNG;
      res_o.width       = {hdr_i[16], hdr_i[17], hdr_i[18], hdr_i[19]};
      res_o.height      = {hdr_i[20], hdr_i[21], hdr_i[22], hdr_i[23]};
    end else if (is_gif) begin
      res_o.format_code = FMT_GIF;
      res_o.width       = {16'h0000, hdr_i[7], hdr_i[6]};
      res_o.height      = {16'h0000, hdr_i[9], hdr_i[8]};
    end else if (is_webp) begin
      if (hdr_i[15] == 8'h20) begin
        res_o.format_code = FMT_VP8;
        res_o.width       = {16'h0000, {hdr_i[27], hdr_i[26]} & Vp8Mask};
        res_o.height      = {16'h0000, {hdr_i[29], hdr_i[28]} & Vp8Mask};
      end else if (hdr_i[15] == 8'h4c) begin
        res_o.format_code = FMT_VP8L;
        res_o.width       = {18'h0, vp8l_bits[13:0]} + 32'd1;
        res_o.height      = {18'h0, vp8l_bits[27:14]} + 32'd1;
      end else begin
        res_o.format_code = FMT_VP8X;
        res_o.width       = {8'h00, hdr_i[26], hdr_i[25], hdr_i[24]} + 32'd1;
        res_o.height      = {8'h00, hdr_i[29], hdr_i[28], hdr_i[27]} + 32'd1;
      end
    end else if (len_i.ge4 && hdr_i[0] == ByteMarker && hdr_i[1] == ByteSoi &&
                 jpeg_i.ok) begin
      res_o.format_code = FMT_JPEG;
      res_o.width       = {16'h0000, jpeg_i.width};
      res_o.height      = {16'h0000, jpeg_i.height};
    end
    res_o.found = (res_o.format_code != FMT_NONE);
  end

endmodule

`default_nettype wire

FILE: rtl/image_header_size_sniffer_top.sv
// ----------------------------------------------------------------------------
// image_header_size_sniffer_top
// Byte-stream sniffer that reports image format and dimensions per file.
// ----------------------------------------------------------------------------
// Usage:
//   in_i carries one file byte per word; last_byte marks the final byte.
//   out_o carries one word per file: found, format_code, width, height.
//   Non-final bytes give no output word.
// Timing:
//   One byte accepted per cycle, unless a final byte waits on a full output
//   register. A byte is registered on accept and processed from that
//   register; the result word for a final byte is registered in the output
//   register when that byte is processed. Throughput is set by the input
//   register and the walker / decode path: one byte per cycle when not stalled.
// Reset:
//   All control state clears at once; the block takes bytes right after
//   reset. After each final byte the parse state returns to its reset values.
// Stall:
//   A result waiting in the output register does not block further bytes;
//   only a second final byte stalls until that result is taken.
// ----------------------------------------------------------------------------
`default_nettype none

module image_header_size_sniffer_top
  import ihs_pkg::*;
#(
  parameter int unsigned POSITION_BITS = PositionBitsDef
) (
  input  wire logic  clk_i,
  input  wire logic  rst_ni,
  ihs_in_if.sink     in_i,
  ihs_out_if.source  out_o
);

  localparam int unsigned P = POSITION_BITS;
  localparam logic [P-1:0] PosMax = {P{1'b1}};

  logic         in_valid_q;
  logic [7:0]   byte_q;
  logic         last_q;
  logic [P-1:0] pos_q;
  hdr_arr_t     hdr_q;
  hdr_arr_t     hdr_view;
  logic         out_valid_q;
  result_t      out_q;

  logic         out_free;
  logic         fire;
  logic         in_accept;
  logic [P-1:0] pos_inc;
  len_flags_t   len_flags;
  jpeg_res_t    jpeg_res;
  result_t      result;

  assign out_free  = !out_valid_q || out_o.ready;
  assign fire      = in_valid_q && (!last_q || out_free);
  assign in_i.ready = !in_valid_q || fire;
  assign in_accept = in_i.valid && in_i.ready;
  assign pos_inc   = (pos_q == PosMax) ? PosMax : pos_q + {{(P-1){1'b0}}, 1'b1};

  // header bytes as seen after this byte is stored
  always_comb begin
    for (int k = 0; k < HdrLen; k++) begin
      hdr_view[k] = (pos_q == P'(k)) ? byte_q : hdr_q[k];
    end
  end

  assign len_flags.ge4  = (pos_inc >= P'(4));
  assign len_flags.ge10 = (pos_inc >= P'(10));
  assign len_flags.ge24 = (pos_inc >= P'(24));
  assign len_flags.ge30 = (pos_inc >= P'(30));

  ihs_jpeg_walk #(
    .POSITION_BITS(P)
  ) u_walk (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .step_i (fire),
    .clear_i(fire && last_q),
    .pos_i  (pos_q),
    .byte_i (byte_q),
    .res_o  (jpeg_res)
  );

  ihs_decode u_decode (
    .hdr_i (hdr_view),
    .len_i (len_flags),
    .jpeg_i(jpeg_res),
    .res_o (result)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (in_accept) begin
      in_valid_q <= 1'b1;
    end else if (fire) begin
      in_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      byte_q <= in_i.data_byte;
      last_q <= in_i.last_byte;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q <= '0;
    end else if (fire) begin
      pos_q <= last_q ? '0 : pos_inc;
    end
  end

  always_ff @(posedge clk_i) begin
    if (fire) begin
      hdr_q <= hdr_view;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (fire && last_q) begin
      out_valid_q <= 1'b1;
    end else if (out_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (fire && last_q) begin
      out_q <= result;
    end
  end

  assign out_o.valid       = out_valid_q;
  assign out_o.found       = out_q.found;
  assign out_o.format_code = out_q.format_code;
  assign out_o.width       = out_q.width;
  assign out_o.height      = out_q.height;

  a_out_from_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(fire && last_q))
    else $error("output word without a final byte");

  a_not_found_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && !out_q.found) |->
      (out_q.format_code == FMT_NONE && out_q.width == 32'd0 && out_q.height == 32'd0))
    else $error("not-found word carries nonzero fields");

  a_stall_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_i.ready |-> (in_valid_q && last_q && out_valid_q && !out_o.ready))
    else $error("input stalled without a blocked final byte");

  a_pos_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (fire && last_q) |=> (pos_q == '0))
    else $error("position not cleared after final byte");

endmodule

`default_nettype wire

FILE: test/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for image_header_size_sniffer_top. Sends whole files
// (PNG, GIF, WEBP, JPEG, truncated, corrupted, noise) one byte word at a
// time, predicts the size word of every file and checks each output word in
// order, under random gaps and backpressure.
// ----------------------------------------------------------------------------

module tb_top;
  import ihs_pkg::*;

  typedef logic [7:0] byte_q_t[$];

  localparam int unsigned StallLimit    = 5000;
  localparam int unsigned BytesPerPhase = 390;
  localparam longint unsigned PosMax    = (64'd1 << PositionBitsDef) - 64'd1;

  logic clk_i = 1'b0;
  logic rst_ni;

  ihs_in_if  byte_if ();
  ihs_out_if dims_if ();

  image_header_size_sniffer_top dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (byte_if),
    .out_o  (dims_if)
  );

  always #5 clk_i = ~clk_i;

  // sniffer state mirror
  logic [7:0]      hdr [HdrLen];
  longint unsigned byte_pos, next_pos, sof_pos;
  logic [15:0]     seg_len;
  logic [31:0]     sof_dims;
  logic            sof_seen;
  walk_phase_e     phase;

  result_t     pending_dims [$];
  int unsigned src_idle_pct = 0;
  int unsigned snk_idle_pct = 0;
  int unsigned idle_cycles  = 0;
  int unsigned bytes_sent   = 0;
  int unsigned files_sent   = 0;
  int unsigned dims_checked = 0;
  int unsigned mismatches   = 0;
  int unsigned fmt_seen [8];

  function automatic void clear_sniffer();
    foreach (hdr[i]) hdr[i] = 8'h00;
    byte_pos = 0;
    next_pos = 2;
    sof_pos  = 0;
    seg_len  = '0;
    sof_dims = '0;
    sof_seen = 1'b0;
    phase    = PH_SEEK;
  endfunction

  function automatic longint unsigned clamp_pos(longint unsigned v);
    return (v > PosMax) ? PosMax : v;
  endfunction

  function automatic bit is_sof_marker(logic [7:0] m);
    return m >= SofLo && m <= SofHi && m != Dht && m != Jpg && m != Dac;
  endfunction

  function automatic void walk_jpeg(longint unsigned p, logic [7:0] b);
    longint unsigned t;
    longint unsigned off;
    case (phase)
      PH_SEEK: begin
        if (p >= next_pos) begin
          if (b == ByteMarker) begin
            next_pos = p;
            phase    = PH_MARK;
          end else begin
            next_pos = clamp_pos(p + 1);
          end
        end
      end
      PH_MARK: begin
        if (is_sof_marker(b)) begin
          sof_pos  = next_pos;
          sof_dims = '0;
          phase    = PH_SOF;
        end else begin
          phase = PH_LENHI;
        end
      end
      PH_LENHI: begin
        seg_len = {b, 8'h00};
        phase   = PH_LENLO;
      end
      PH_LENLO: begin
        seg_len = seg_len | {8'h00, b};
        t = next_pos + 2 + seg_len;
        if (t <= p) t = p + 1;
        next_pos = clamp_pos(t);
        phase    = PH_SEEK;
      end
      PH_SOF: begin
        off = p - sof_pos;
        if (off >= 5 && off <= 8) sof_dims |= 32'(b) << (8 * (8 - off));
        if (off == 8) begin
          sof_seen = 1'b1;
          phase    = PH_DONE;
        end
      end
      default: ;
    endcase
  endfunction

  function automatic result_t file_dims(longint unsigned n);
    result_t     r;
    logic [31:0] bits;
    r = '0;
    if (n >= 24 && hdr[0] == BytePngSig && {hdr[1], hdr[2], hdr[3]} == "PNG") begin
      r.format_code = FMT_PNG;
      r.width       = {hdr[16], hdr[17], hdr[18], hdr[19]};
      r.height      = {hdr[20], hdr[21], hdr[22], hdr[23]};
    end else if (n >= 10 && {hdr[0], hdr[1], hdr[2]} == "GIF") begin
      r.format_code = FMT_GIF;
      r.width       = {16'h0, hdr[7], hdr[6]};
      r.height      = {16'h0, hdr[9], hdr[8]};
    end else if (n >= 30 && {hdr[0], hdr[1], hdr[2], hdr[3]} == "RIFF" &&
                 {hdr[8], hdr[9], hdr[10], hdr[11]} == "WEBP" &&
                 {hdr[12], hdr[13], hdr[14]} == "VP8" &&
                 (hdr[15] == " " || hdr[15] == "L" || hdr[15] == "X")) begin
      if (hdr[15] == " ") begin
        r.format_code = FMT_VP8;
        r.width       = {16'h0, {hdr[27], hdr[26]} & Vp8Mask};
        r.height      = {16'h0, {hdr[29], hdr[28]} & Vp8Mask};
      end else if (hdr[15] == "L") begin
        bits          = {hdr[24], hdr[23], hdr[22], hdr[21]};
        r.format_code = FMT_VP8L;
        r.width       = 32'(bits[13:0]) + 32'd1;
        r.height      = 32'(bits[27:14]) + 32'd1;
      end else begin
        r.format_code = FMT_VP8X;
        r.width       = {8'h0, hdr[26], hdr[25], hdr[24]} + 32'd1;
        r.height      = {8'h0, hdr[29], hdr[28], hdr[27]} + 32'd1;
      end
    end else if (n >= 4 && hdr[0] == ByteMarker && hdr[1] == ByteSoi && sof_seen &&
                 n >= sof_pos + 10) begin
      r.format_code = FMT_JPEG;
      r.width       = {16'h0, sof_dims[15:0]};
      r.height      = {16'h0, sof_dims[31:16]};
    end
    r.found = (r.format_code != FMT_NONE);
    return r;
  endfunction

  function automatic void sniff_byte(logic [7:0] b, logic last);
    if (byte_pos < HdrLen) hdr[byte_pos] = b;
    walk_jpeg(byte_pos, b);
    byte_pos = (byte_pos < PosMax) ? byte_pos + 1 : PosMax;
    if (last) begin
      pending_dims.push_back(file_dims(byte_pos));
      clear_sniffer();
    end
  endfunction

  // file builders
  function automatic void push_rand(ref byte_q_t f, input int n);
    repeat (n) f.push_back(8'($urandom_range(0, 255)));
  endfunction

  function automatic void push_tag(ref byte_q_t f, input logic [31:0] tag, input int n);
    for (int i = n - 1; i >= 0; i--) f.push_back(tag[8*i +: 8]);
  endfunction

  function automatic void push_fill(ref byte_q_t f, input int fill, input int n);
    if (fill < 0) push_rand(f, n);
    else repeat (n) f.push_back(8'(fill));
  endfunction

  function automatic byte_q_t png_file(logic [31:0] w, logic [31:0] h, int extra);
    byte_q_t f;
    f = {};
    f.push_back(BytePngSig);
    push_tag(f, "PNG", 3);
    push_rand(f, 12);
    push_tag(f, w, 4);
    push_tag(f, h, 4);
    push_rand(f, extra);
    return f;
  endfunction

  function automatic byte_q_t gif_file(logic [15:0] w, logic [15:0] h, int extra);
    byte_q_t f;
    f = {};
    push_tag(f, "GIF", 3);
    push_rand(f, 3);
    push_tag(f, {w[7:0], w[15:8]}, 2);
    push_tag(f, {h[7:0], h[15:8]}, 2);
    push_rand(f, extra);
    return f;
  endfunction

  function automatic byte_q_t webp_file(logic [7:0] kind, int fill, int extra);
    byte_q_t f;
    f = {};
    push_tag(f, "RIFF", 4);
    push_rand(f, 4);
    push_tag(f, "WEBP", 4);
    push_tag(f, "VP8", 3);
    f.push_back(kind);
    push_fill(f, fill, 14);
    push_rand(f, extra);
    return f;
  endfunction

  function automatic byte_q_t jpeg_file(int nseg, bit short_len, bit far_len,
                                        logic [15:0] w, logic [15:0] h, int tail);
    byte_q_t    f;
    logic [7:0] mk;
    int         len;
    f = {};
    f.push_back(ByteMarker);
    f.push_back(ByteSoi);
    for (int s = 0; s < nseg; s++) begin
      repeat ($urandom_range(0, 2)) f.push_back(8'($urandom_range(0, 254)));
      f.push_back(ByteMarker);
      case ($urandom_range(0, 5))
        0: mk = Dht;
        1: mk = Jpg;
        2: mk = Dac;
        default: do mk = 8'($urandom_range(0, 255)); while (is_sof_marker(mk));
      endcase
      f.push_back(mk);
      len = (short_len && $urandom_range(0, 1)) ? $urandom_range(0, 1) : $urandom_range(2, 7);
      f.push_back((far_len && s == 0) ? 8'($urandom_range(1, 255)) : 8'h00);
      f.push_back(8'(len));
      if (len >= 2) push_rand(f, len - 2);
    end
    f.push_back(ByteMarker);
    do mk = 8'($urandom_range(SofLo, SofHi)); while (!is_sof_marker(mk));
    f.push_back(mk);
    f.push_back(8'h00);
    f.push_back(8'h11);
    push_rand(f, 1);
    push_tag(f, h, 2);
    push_tag(f, w, 2);
    if (tail > 0) push_rand(f, tail);
    else repeat (-tail) void'(f.pop_back());
    return f;
  endfunction

  function automatic byte_q_t any_file();
    logic [7:0] kinds [3];
    kinds = '{" ", "L", "X"};
    case ($urandom_range(0, 3))
      0: return png_file($urandom, $urandom, $urandom_range(0, 4));
      1: return gif_file(16'($urandom), 16'($urandom), $urandom_range(0, 4));
      2: return webp_file(($urandom_range(0, 9) == 0) ? 8'($urandom_range(0, 255)) :
                          kinds[$urandom_range(0, 2)], -1, $urandom_range(0, 3));
      default: return jpeg_file($urandom_range(0, 4), 1'($urandom_range(0, 1)),
                                $urandom_range(0, 9) == 0, 16'($urandom), 16'($urandom),
                                ($urandom_range(0, 9) == 0) ? -$urandom_range(0, 4) :
                                $urandom_range(1, 3));
    endcase
  endfunction

  // byte word driver
  task automatic send_byte(input logic [7:0] b, input logic last);
    @(negedge clk_i);
    while ($urandom_range(0, 99) < src_idle_pct) begin
      byte_if.valid = 1'b0;
      @(negedge clk_i);
    end
    byte_if.valid     = 1'b1;
    byte_if.data_byte = b;
    byte_if.last_byte = last;
    do @(posedge clk_i); while (!byte_if.ready);
    sniff_byte(b, last);
    bytes_sent++;
    if (last) files_sent++;
  endtask

  task automatic send_file(input byte_q_t f);
    foreach (f[i]) send_byte(f[i], i == f.size() - 1);
  endtask

  always @(negedge clk_i) dims_if.ready = ($urandom_range(0, 99) >= snk_idle_pct);

  task automatic check_field(input string name, input logic [31:0] exp, input logic [31:0] act);
    if (act !== exp) begin
      $display("%0t: %s mismatch, expected %0h actual %0h", $time, name, exp, act);
      mismatches++;
    end
  endtask

  always @(posedge clk_i) begin
    result_t exp;
    if (rst_ni && dims_if.valid && dims_if.ready) begin
      if (pending_dims.size() == 0) begin
        $display("%0t: unexpected size word, expected none actual %0h/%0h/%0h/%0h", $time,
                 dims_if.found, dims_if.format_code, dims_if.width, dims_if.height);
        mismatches++;
      end else begin
        exp = pending_dims.pop_front();
        check_field("found", 32'(exp.found), 32'(dims_if.found));
        check_field("format_code", 32'(exp.format_code), 32'(dims_if.format_code));
        check_field("width", exp.width, dims_if.width);
        check_field("height", exp.height, dims_if.height);
        dims_checked++;
        fmt_seen[dims_if.format_code]++;
      end
    end
  end

  always @(posedge clk_i) begin
    if ((byte_if.valid && byte_if.ready) || (dims_if.valid && dims_if.ready)) begin
      idle_cycles = 0;
    end else if (rst_ni) begin
      idle_cycles++;
      if (idle_cycles >= StallLimit) begin
        $display("%0t: no progress for %0d cycles", $time, StallLimit);
        $display("Regression FAIL");
        $finish;
      end
    end
  end

  // tests
  task automatic test_png();
    byte_q_t f;
    send_file(png_file(32'hffff_ffff, 32'hffff_ffff, 0));
    send_file(png_file(32'h0, 32'h0, 2));
    f = png_file($urandom, $urandom, 0);
    void'(f.pop_back());
    send_file(f);
  endtask

  task automatic test_gif();
    byte_q_t f;
    send_file(gif_file(16'hffff, 16'h0000, 0));
    send_file(gif_file(16'h0000, 16'hffff, 3));
    f = gif_file(16'h1234, 16'h5678, 0);
    void'(f.pop_back());
    send_file(f);
  endtask

  task automatic test_webp();
    byte_q_t f;
    send_file(webp_file(" ", 8'hff, 0));
    send_file(webp_file("L", 8'h00, 0));
    send_file(webp_file("L", 8'hff, 1));
    send_file(webp_file("X", 8'hff, 0));
    send_file(webp_file("X", 8'h00, 2));
    send_file(webp_file("Y", -1, 0));
    f = webp_file(" ", -1, 0);
    void'(f.pop_back());
    send_file(f);
  endtask

  task automatic test_jpeg();
    send_file(jpeg_file(0, 1'b0, 1'b0, 16'h0000, 16'h0000, 1));
    send_file(jpeg_file(2, 1'b0, 1'b0, 16'hffff, 16'hffff, 1));
    send_file(jpeg_file(3, 1'b1, 1'b0, 16'h1234, 16'h5678, 0));
    send_file(jpeg_file(2, 1'b1, 1'b0, 16'h00ff, 16'hff00, 2));
    send_file(jpeg_file(1, 1'b0, 1'b1, 16'h0101, 16'h0202, 2));
    send_file('{ByteMarker, ByteSoi, SofLo});
  endtask

  task automatic test_noise();
    byte_q_t f;
    send_file('{8'h00});
    send_file('{8'hff});
    send_file('{"G", "I"});
    f = {};
    push_rand(f, 40);
    send_file(f);
  endtask

  task automatic test_random_mix(input int unsigned src_pct, input int unsigned snk_pct);
    byte_q_t     f;
    int unsigned start;
    int unsigned pick;
    src_idle_pct = src_pct;
    snk_idle_pct = snk_pct;
    start = bytes_sent;
    while (bytes_sent - start < BytesPerPhase) begin
      pick = $urandom_range(0, 99);
      if (pick < 75) begin
        f = any_file();
      end else if (pick < 90) begin
        f = any_file();
        if ($urandom_range(0, 1) && f.size() > 1)
          repeat ($urandom_range(1, f.size() - 1)) void'(f.pop_back());
        else
          f[$urandom_range(0, 3)] ^= 8'(1 << $urandom_range(0, 7));
      end else begin
        f = {};
        if ($urandom_range(0, 1)) begin
          f.push_back(ByteMarker);
          f.push_back(ByteSoi);
        end
        push_rand(f, $urandom_range(1, 12));
      end
      send_file(f);
    end
  endtask

  initial begin
    rst_ni            = 1'b0;
    byte_if.valid     = 1'b0;
    byte_if.data_byte = 8'h00;
    byte_if.last_byte = 1'b0;
    dims_if.ready     = 1'b0;
    foreach (fmt_seen[i]) fmt_seen[i] = 0;
    clear_sniffer();
    repeat (5) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    src_idle_pct = 23;
    snk_idle_pct = 70;
    test_png();
    test_gif();
    test_webp();
    test_jpeg();
    test_noise();
    test_random_mix(23, 70);
    test_random_mix(70, 23);
    test_random_mix(0, 0);

    @(negedge clk_i);
    byte_if.valid = 1'b0;
    while (pending_dims.size() != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);

    $display("Sent %0d files in %0d bytes; %0d size words checked, %0d mismatches",
             files_sent, bytes_sent, dims_checked, mismatches);
    $display("Formats seen: none %0d png %0d gif %0d vp8 %0d vp8l %0d vp8x %0d jpeg %0d",
             fmt_seen[FMT_NONE], fmt_seen[FMT_PNG], fmt_seen[FMT_GIF], fmt_seen[FMT_VP8],
             fmt_seen[FMT_VP8L], fmt_seen[FMT_VP8X], fmt_seen[FMT_JPEG]);
    if (mismatches == 0 && pending_dims.size() == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
